// ===== hw/rtl/dmsh_pkg.sv =====
// shared types and constants for the double modulus substring hash block
// no dependencies; used by dmsh_modmul and double_mod_substring_hash_top

package dmsh_pkg;

    localparam int DATA_W   = 30;
    localparam int MU_W     = 31;
    localparam int IDX_W    = 12;
    localparam int BYTE_W   = 8;
    localparam int MAX_LEN_DEF = 4096;

    localparam logic [DATA_W-1:0] MOD_FIRST  = 30'd1001864327;
    localparam logic [DATA_W-1:0] MOD_SECOND = 30'd1001265673;

    localparam logic [DATA_W-1:0] BASE_FIRST_RST  = 30'd257;
    localparam logic [DATA_W-1:0] BASE_SECOND_RST = 30'd367;

    // barrett factors, floor(2^60 / modulus)
    localparam logic [63:0] MU_FIRST_FULL  = 64'h1000_0000_0000_0000 / 64'(MOD_FIRST);
    localparam logic [63:0] MU_SECOND_FULL = 64'h1000_0000_0000_0000 / 64'(MOD_SECOND);
    localparam logic [MU_W-1:0] MU_FIRST   = MU_FIRST_FULL[MU_W-1:0];
    localparam logic [MU_W-1:0] MU_SECOND  = MU_SECOND_FULL[MU_W-1:0];

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef enum logic {
        CFG_BASE_FIRST  = 1'b0,
        CFG_BASE_SECOND = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_A_ISSUE1,
        ST_A_ISSUE2,
        ST_A_WAIT,
        ST_Q_ISSUE,
        ST_Q_WAIT,
        ST_Q_DONE
    } state_t;

endpackage

// ===== hw/rtl/dmsh_modmul.sv =====
// pipelined modular multiplier, four register stages, barrett reduction
// depends on dmsh_pkg for widths

module dmsh_modmul
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic [dmsh_pkg::DATA_W-1:0]             a,
    input  logic [dmsh_pkg::DATA_W-1:0]             b,
    input  logic [dmsh_pkg::DATA_W-1:0]             modulus,
    input  logic [dmsh_pkg::MU_W-1:0]               mu,
    output logic                                    out_valid,
    output logic [dmsh_pkg::DATA_W-1:0]             result
);

    localparam int DW = dmsh_pkg::DATA_W;
    localparam int PW = 2 * DW;
    localparam int EW = 2 * dmsh_pkg::MU_W;
    localparam int RW = DW + 2;

    logic [3:0]    v_reg;
    logic [PW-1:0] prod_reg;
    logic [EW-1:0] est_reg;
    logic [RW-1:0] low1_reg;
    logic [RW-1:0] low2_reg;
    logic [RW-1:0] qm_reg;
    logic [DW-1:0] result_reg;

    logic [PW-1:0] prod_next;
    logic [EW-1:0] est_next;
    logic [RW-1:0] qm_next;
    logic [RW-1:0] r0;
    logic [RW-1:0] r1;
    logic [RW-1:0] r2;
    logic [RW-1:0] m1;
    logic [RW-1:0] m2;
    logic [DW-1:0] result_next;

    always_comb
    begin
        prod_next = a * b;
        est_next  = prod_reg[PW-1:DW-1] * mu;
        // estimated quotient is below 2^30, only the low bits of q*m are needed
        qm_next   = est_reg[EW-1:DW+1] * modulus;
        m1 = {2'b00, modulus};
        m2 = {1'b0, modulus, 1'b0};
        r0 = low2_reg - qm_reg;
        r1 = r0 - m1;
        r2 = r0 - m2;
        if (r0 >= m2)
        begin
            result_next = r2[DW-1:0];
        end
        else if (r0 >= m1)
        begin
            result_next = r1[DW-1:0];
        end
        else
        begin
            result_next = r0[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        est_reg    <= est_next;
        low1_reg   <= prod_reg[RW-1:0];
        low2_reg   <= low1_reg;
        qm_reg     <= qm_next;
        result_reg <= result_next;
    end

    assign out_valid = v_reg[3];
    assign result    = result_reg;

endmodule

// ===== hw/rtl/double_mod_substring_hash_top.sv =====
// top level of the double modulus substring hash block
// depends on dmsh_pkg and dmsh_modmul
//
// usage:
//   input channel (in_valid / in_stall) takes one request word: append a byte,
//   query a substring hash from left_index to right_index, or clear the string.
//   output channel (out_valid / out_stall) gives one result word per query:
//   both lane hashes and bad_range. appends, clears and unused codes give none.
//   configuration: cfg_we writes cfg_data into base_first (index 0) or
//   base_second (index 1); only write while the block is idle.
// sequence:
//   clear and unused codes leave the block idle. append and a good query first
//   read the prefix and power memories synchronously, then run the four stage
//   modular multiplier per lane (an append issues two products back to back),
//   then write back or do a final subtract; a good query reads the prefix entry
//   past right_index as it issues its product. a bad query goes straight to done.
// reset: length goes to zero and bases to 257 and 367; memories are not cleared,
//   entry zero is supplied as a constant on read.
// stall: the output register holds a word while out_stall is high; the block
//   keeps accepting requests until a finished query waits in its result register.

module double_mod_substring_hash_top
#(
    parameter int MAX_LEN = dmsh_pkg::MAX_LEN_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         req_type,
    input  logic [dmsh_pkg::BYTE_W-1:0]        char_code,
    input  logic [dmsh_pkg::IDX_W-1:0]         left_index,
    input  logic [dmsh_pkg::IDX_W-1:0]         right_index,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [dmsh_pkg::DATA_W-1:0]        hash_first,
    output logic [dmsh_pkg::DATA_W-1:0]        hash_second,
    output logic                               bad_range,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [dmsh_pkg::DATA_W-1:0]        cfg_data
);

    localparam int DW     = dmsh_pkg::DATA_W;
    localparam int ADDR_W = $clog2(MAX_LEN + 1);
    localparam int CMP_W  = (ADDR_W > dmsh_pkg::IDX_W ? ADDR_W : dmsh_pkg::IDX_W) + 1;

    // add a byte to a residue, result stays below the modulus
    function automatic logic [DW-1:0] mod_add_byte(input logic [DW-1:0] x,
                                                   input logic [dmsh_pkg::BYTE_W-1:0] c,
                                                   input logic [DW-1:0] m);
        logic [DW:0] s;
        logic [DW:0] t;
        begin
            s = {1'b0, x} + (DW+1)'(c);
            t = s - {1'b0, m};
            mod_add_byte = (s >= {1'b0, m}) ? t[DW-1:0] : s[DW-1:0];
        end
    endfunction

    function automatic logic [DW-1:0] mod_sub(input logic [DW-1:0] x,
                                              input logic [DW-1:0] y,
                                              input logic [DW-1:0] m);
        logic [DW:0] d;
        begin
            d = {1'b0, x} - {1'b0, y} + {1'b0, m};
            mod_sub = (x >= y) ? (x - y) : d[DW-1:0];
        end
    endfunction

    // memories: {second lane, first lane}
    logic [2*DW-1:0] prefix_mem [0:MAX_LEN];
    logic [2*DW-1:0] power_mem  [0:MAX_LEN];

    dmsh_pkg::state_t state_reg;
    dmsh_pkg::state_t state_next;

    logic [ADDR_W-1:0] length_reg;
    logic [DW-1:0]     base_first_reg;
    logic [DW-1:0]     base_second_reg;
    logic [2*DW-1:0]   pf_rd_reg;
    logic [2*DW-1:0]   pw_rd_reg;
    logic              pf_zero_reg;
    logic              pw_zero_reg;
    logic [ADDR_W-1:0] rp1_reg;
    logic [dmsh_pkg::BYTE_W-1:0] byte_reg;
    logic              got_reg;
    logic [DW-1:0]     sum_first_reg;
    logic [DW-1:0]     sum_second_reg;
    logic [DW-1:0]     res_first_reg;
    logic [DW-1:0]     res_second_reg;
    logic              res_bad_reg;
    logic              out_valid_reg;
    logic [DW-1:0]     hash_first_reg;
    logic [DW-1:0]     hash_second_reg;
    logic              bad_range_reg;

    logic              accept;
    logic              out_free;
    logic [CMP_W-1:0]  left_w;
    logic [CMP_W-1:0]  right_w;
    logic [CMP_W-1:0]  len_w;
    logic [CMP_W-1:0]  span_w;
    logic [CMP_W-1:0]  rp1_w;
    logic              q_bad;
    logic              full;
    logic [ADDR_W-1:0] pf_addr;
    logic [ADDR_W-1:0] pw_addr;
    logic              pf_rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    logic [2*DW-1:0]   pf_val;
    logic [2*DW-1:0]   pw_val;

    logic              mm_in_valid;
    logic [DW-1:0]     mm_a_first;
    logic [DW-1:0]     mm_b_first;
    logic [DW-1:0]     mm_a_second;
    logic [DW-1:0]     mm_b_second;
    logic              mm_valid_first;
    logic              mm_valid_second;
    logic [DW-1:0]     mm_res_first;
    logic [DW-1:0]     mm_res_second;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != dmsh_pkg::ST_IDLE);

    always_comb
    begin
        left_w  = CMP_W'(left_index);
        right_w = CMP_W'(right_index);
        len_w   = CMP_W'(length_reg);
        span_w  = right_w - left_w + CMP_W'(1);
        rp1_w   = right_w + CMP_W'(1);
        q_bad   = (left_w > right_w) || (right_w >= len_w);
        full    = (length_reg == ADDR_W'(MAX_LEN));
        wr_addr = length_reg + ADDR_W'(1);
        pf_val  = pf_zero_reg ? '0 : pf_rd_reg;
        pw_val  = pw_zero_reg ? {DW'(1), DW'(1)} : pw_rd_reg;
    end

    // read addresses: append reads entry length, query reads left and span, then right plus one
    always_comb
    begin
        pf_rd_en = 1'b0;
        pf_addr  = length_reg;
        pw_addr  = length_reg;
        if (state_reg == dmsh_pkg::ST_Q_ISSUE)
        begin
            pf_rd_en = 1'b1;
            pf_addr  = rp1_reg;
        end
        else if (accept)
        begin
            pf_rd_en = 1'b1;
            if (req_type == dmsh_pkg::REQ_QUERY)
            begin
                pf_addr = ADDR_W'(left_w);
                pw_addr = ADDR_W'(span_w);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pf_rd_en)
        begin
            pf_rd_reg   <= prefix_mem[pf_addr];
            pf_zero_reg <= (pf_addr == '0);
        end
        if (accept)
        begin
            pw_rd_reg   <= power_mem[pw_addr];
            pw_zero_reg <= (pw_addr == '0);
        end
        if (wr_en)
        begin
            prefix_mem[wr_addr] <= {sum_second_reg, sum_first_reg};
            power_mem[wr_addr]  <= {mm_res_second, mm_res_first};
        end
    end

    // multiplier operands per state
    always_comb
    begin
        mm_in_valid = 1'b0;
        mm_a_first  = pf_val[DW-1:0];
        mm_a_second = pf_val[2*DW-1:DW];
        mm_b_first  = base_first_reg;
        mm_b_second = base_second_reg;
        unique case (state_reg)
            dmsh_pkg::ST_A_ISSUE1:
            begin
                mm_in_valid = 1'b1;
            end
            dmsh_pkg::ST_A_ISSUE2:
            begin
                mm_in_valid = 1'b1;
                mm_a_first  = pw_val[DW-1:0];
                mm_a_second = pw_val[2*DW-1:DW];
            end
            dmsh_pkg::ST_Q_ISSUE:
            begin
                mm_in_valid = 1'b1;
                mm_b_first  = pw_val[DW-1:0];
                mm_b_second = pw_val[2*DW-1:DW];
            end
            default:
            begin
                mm_in_valid = 1'b0;
            end
        endcase
    end

    dmsh_modmul u_mm_first
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mm_in_valid),
        .a         (mm_a_first),
        .b         (mm_b_first),
        .modulus   (dmsh_pkg::MOD_FIRST),
        .mu        (dmsh_pkg::MU_FIRST),
        .out_valid (mm_valid_first),
        .result    (mm_res_first)
    );

    dmsh_modmul u_mm_second
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mm_in_valid),
        .a         (mm_a_second),
        .b         (mm_b_second),
        .modulus   (dmsh_pkg::MOD_SECOND),
        .mu        (dmsh_pkg::MU_SECOND),
        .out_valid (mm_valid_second),
        .result    (mm_res_second)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        wr_en      = 1'b0;
        unique case (state_reg)
            dmsh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        dmsh_pkg::REQ_APPEND:
                        begin
                            if (!full)
                            begin
                                state_next = dmsh_pkg::ST_A_ISSUE1;
                            end
                        end
                        dmsh_pkg::REQ_QUERY:
                        begin
                            state_next = q_bad ? dmsh_pkg::ST_Q_DONE : dmsh_pkg::ST_Q_ISSUE;
                        end
                        default:
                        begin
                            state_next = dmsh_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            dmsh_pkg::ST_A_ISSUE1:
            begin
                state_next = dmsh_pkg::ST_A_ISSUE2;
            end
            dmsh_pkg::ST_A_ISSUE2:
            begin
                state_next = dmsh_pkg::ST_A_WAIT;
            end
            dmsh_pkg::ST_A_WAIT:
            begin
                // second product out is the power, write both entries then
                if (mm_valid_first && got_reg)
                begin
                    wr_en      = 1'b1;
                    state_next = dmsh_pkg::ST_IDLE;
                end
            end
            dmsh_pkg::ST_Q_ISSUE:
            begin
                state_next = dmsh_pkg::ST_Q_WAIT;
            end
            dmsh_pkg::ST_Q_WAIT:
            begin
                if (mm_valid_first)
                begin
                    state_next = dmsh_pkg::ST_Q_DONE;
                end
            end
            dmsh_pkg::ST_Q_DONE:
            begin
                if (out_free)
                begin
                    state_next = dmsh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmsh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dmsh_pkg::ST_IDLE;
            length_reg      <= '0;
            base_first_reg  <= dmsh_pkg::BASE_FIRST_RST;
            base_second_reg <= dmsh_pkg::BASE_SECOND_RST;
            got_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dmsh_pkg::CFG_BASE_FIRST:  base_first_reg  <= cfg_data;
                    dmsh_pkg::CFG_BASE_SECOND: base_second_reg <= cfg_data;
                    default:                   base_first_reg  <= base_first_reg;
                endcase
            end
            if (accept && req_type == dmsh_pkg::REQ_CLEAR)
            begin
                length_reg <= '0;
            end
            else if (wr_en)
            begin
                length_reg <= wr_addr;
            end
            if (state_reg == dmsh_pkg::ST_A_ISSUE1)
            begin
                got_reg <= 1'b0;
            end
            else if (state_reg == dmsh_pkg::ST_A_WAIT && mm_valid_first)
            begin
                got_reg <= 1'b1;
            end
            if (state_reg == dmsh_pkg::ST_Q_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= char_code;
            rp1_reg  <= ADDR_W'(rp1_w);
            res_first_reg  <= '0;
            res_second_reg <= '0;
            res_bad_reg    <= q_bad;
        end
        if (state_reg == dmsh_pkg::ST_A_WAIT && mm_valid_first && !got_reg)
        begin
            sum_first_reg  <= mod_add_byte(mm_res_first, byte_reg, dmsh_pkg::MOD_FIRST);
            sum_second_reg <= mod_add_byte(mm_res_second, byte_reg, dmsh_pkg::MOD_SECOND);
        end
        if (state_reg == dmsh_pkg::ST_Q_WAIT && mm_valid_first)
        begin
            res_first_reg  <= mod_sub(pf_val[DW-1:0], mm_res_first, dmsh_pkg::MOD_FIRST);
            res_second_reg <= mod_sub(pf_val[2*DW-1:DW], mm_res_second,
                                      dmsh_pkg::MOD_SECOND);
        end
        if (state_reg == dmsh_pkg::ST_Q_DONE && out_free)
        begin
            hash_first_reg  <= res_first_reg;
            hash_second_reg <= res_second_reg;
            bad_range_reg   <= res_bad_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hash_first  = hash_first_reg;
    assign hash_second = hash_second_reg;
    assign bad_range   = bad_range_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= ADDR_W'(MAX_LEN))
        else $error("string length beyond store depth");

    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        mm_valid_first == mm_valid_second)
        else $error("multiplier lanes out of step");

    a_mm_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mm_valid_first |-> (state_reg == dmsh_pkg::ST_A_WAIT ||
                            state_reg == dmsh_pkg::ST_Q_WAIT))
        else $error("product arrived outside a wait state");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dmsh_pkg::ST_Q_DONE && out_free)
        |=> (out_valid_reg && state_reg == dmsh_pkg::ST_IDLE))
        else $error("finished query word not presented");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_range_reg) |-> (hash_first_reg == '0 && hash_second_reg == '0))
        else $error("bad range word carries a hash");

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for double_mod_substring_hash_top: a directed table, then random
// append / query / clear / unused traffic over several base settings, results checked by a local predictor
// depends on dmsh_pkg and double_mod_substring_hash_top
`timescale 1ns / 100ps

module tb;
    import dmsh_pkg::*;

    localparam int STR_MAX        = MAX_LEN_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CFG_SETTLE     = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [DATA_W-1:0] LANE_MOD [2] = '{MOD_FIRST, MOD_SECOND};

    typedef struct packed {
        logic [DATA_W-1:0] h1;
        logic [DATA_W-1:0] h2;
        logic              bad;
    } hash_word_t;

    typedef struct packed {
        logic [1:0]        req;
        logic [BYTE_W-1:0] ch;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic              typed;
        hash_word_t        res;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        req_type;
    logic [BYTE_W-1:0] char_code;
    logic [IDX_W-1:0]  left_index;
    logic [IDX_W-1:0]  right_index;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] hash_first;
    logic [DATA_W-1:0] hash_second;
    logic              bad_range;
    logic              cfg_we;
    logic              cfg_index;
    logic [DATA_W-1:0] cfg_data;

    // predictor state
    logic [DATA_W-1:0] lane_base [2];
    logic [DATA_W-1:0] prefix_tab [2][0:STR_MAX];
    logic [DATA_W-1:0] power_tab [2][0:STR_MAX];
    int unsigned       str_len;
    hash_word_t        hash_expect_q [$];

    bit          idle_on;
    bit          hold_req;
    int          err_count;
    int unsigned quiet_cycles;
    int unsigned items_sent, n_append, n_drop, n_clear, n_query, n_bad, n_checked;
    int unsigned n_cfg, n_holds;

    // short string, then extremes of the range checks; typed rows read straight off the hash
    dir_row_t dir_tab [22] = '{
        '{REQ_QUERY,  8'h00, 12'd0,    12'd0,    1'b1, '{30'd0, 30'd0, 1'b1}},
        '{REQ_QUERY,  8'h00, 12'd4095, 12'd4095, 1'b1, '{30'd0, 30'd0, 1'b1}},
        '{REQ_APPEND, 8'h00, 12'd0,    12'd0,    1'b0, '0},
        '{REQ_QUERY,  8'h00, 12'd0,    12'd0,    1'b1, '{30'd0, 30'd0, 1'b0}},
        '{REQ_CLEAR,  8'hff, 12'hfff,  12'hfff,  1'b0, '0},
        '{REQ_APPEND, 8'hff, 12'hfff,  12'hfff,  1'b0, '0},
        '{REQ_QUERY,  8'h00, 12'd0,    12'd0,    1'b1, '{30'd255, 30'd255, 1'b0}},
        '{REQ_APPEND, 8'ha5, 12'd0,    12'd0,    1'b0, '0},
        '{REQ_APPEND, 8'h5a, 12'd0,    12'd0,    1'b0, '0},
        '{REQ_APPEND, 8'h01, 12'd0,    12'd0,    1'b0, '0},
        '{REQ_QUERY,  8'h00, 12'd0,    12'd3,    1'b0, '0},
        '{REQ_QUERY,  8'h00, 12'd1,    12'd2,    1'b0, '0},
        '{REQ_QUERY,  8'h00, 12'd2,    12'd1,    1'b1, '{30'd0, 30'd0, 1'b1}},
        '{REQ_QUERY,  8'h00, 12'd0,    12'd4,    1'b1, '{30'd0, 30'd0, 1'b1}},
        '{REQ_QUERY,  8'h00, 12'd4095, 12'd0,    1'b1, '{30'd0, 30'd0, 1'b1}},
        '{REQ_UNUSED, 8'hff, 12'hfff,  12'hfff,  1'b0, '0},
        '{REQ_QUERY,  8'h00, 12'd0,    12'd3,    1'b0, '0},
        '{REQ_QUERY,  8'h00, 12'd3,    12'd3,    1'b1, '{30'd1, 30'd1, 1'b0}},
        '{REQ_QUERY,  8'h00, 12'd0,    12'd0,    1'b1, '{30'd255, 30'd255, 1'b0}},
        '{REQ_CLEAR,  8'h00, 12'd0,    12'd0,    1'b0, '0},
        '{REQ_QUERY,  8'h00, 12'd0,    12'd0,    1'b1, '{30'd0, 30'd0, 1'b1}},
        '{REQ_APPEND, 8'h80, 12'd0,    12'd0,    1'b0, '0}
    };

    double_mod_substring_hash_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .char_code   (char_code),
        .left_index  (left_index),
        .right_index (right_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hash_first  (hash_first),
        .hash_second (hash_second),
        .bad_range   (bad_range),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] mul_mod(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b,
                                                 input logic [DATA_W-1:0] m);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return DATA_W'(p % 64'(m));
    endfunction

    function automatic logic [DATA_W-1:0] add_mod(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b,
                                                 input logic [DATA_W-1:0] m);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] sub_mod(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b,
                                                 input logic [DATA_W-1:0] m);
        return (a >= b) ? a - b : a + (m - b);
    endfunction

    // advance the string state for one accepted word and work out its result, if any
    task automatic predict_hash(input logic [1:0] req, input logic [BYTE_W-1:0] ch,
                                input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi,
                                output bit has_res, output hash_word_t res);
        int unsigned n, span, lo_i, hi_i;
        logic [DATA_W-1:0] lane_hash [2];
        has_res = 1'b0;
        res = '0;
        n = str_len;
        lo_i = lo;
        hi_i = hi;
        if (req != REQ_UNUSED)
            items_sent++;
        case (req)
            REQ_APPEND:
            begin
                n_append++;
                if (n < STR_MAX)
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        prefix_tab[k][n+1] = add_mod(mul_mod(prefix_tab[k][n], lane_base[k],
                                                             LANE_MOD[k]),
                                                     DATA_W'(ch), LANE_MOD[k]);
                        power_tab[k][n+1] = mul_mod(power_tab[k][n], lane_base[k], LANE_MOD[k]);
                    end
                    str_len = n + 1;
                end
                else
                    n_drop++;
            end
            REQ_CLEAR:
            begin
                n_clear++;
                str_len = 0;
            end
            REQ_QUERY:
            begin
                n_query++;
                has_res = 1'b1;
                if (lo_i > hi_i || hi_i >= n)
                begin
                    n_bad++;
                    res.bad = 1'b1;
                end
                else
                begin
                    span = hi_i - lo_i + 1;
                    for (int k = 0; k < 2; k++)
                        lane_hash[k] = sub_mod(prefix_tab[k][hi_i+1],
                                               mul_mod(prefix_tab[k][lo_i], power_tab[k][span],
                                                       LANE_MOD[k]),
                                               LANE_MOD[k]);
                    res.h1 = lane_hash[0];
                    res.h2 = lane_hash[1];
                end
            end
            default: ;
        endcase
    endtask

    // offer one request word, wait for it to be taken, record what it should produce
    task automatic send_word(input logic [1:0] req, input logic [BYTE_W-1:0] ch,
                             input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi,
                             input bit typed = 1'b0, input hash_word_t typed_res = '0);
        bit has_res;
        hash_word_t res;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        char_code   <= ch;
        left_index  <= lo;
        right_index <= hi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_hash(req, ch, lo, hi, has_res, res);
        if (has_res)
            hash_expect_q.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    task automatic send_good_query();
        logic [IDX_W-1:0] lo, hi;
        lo = IDX_W'($urandom_range(0, str_len - 1));
        hi = IDX_W'($urandom_range(lo, str_len - 1));
        send_word(REQ_QUERY, BYTE_W'($urandom), lo, hi);
    endtask

    task automatic random_word();
        int unsigned pick;
        logic [IDX_W-1:0] lo, hi;
        pick = $urandom_range(0, 99);
        lo = IDX_W'($urandom);
        hi = IDX_W'($urandom);
        if (pick < 42)
            send_word(REQ_APPEND, BYTE_W'($urandom), lo, hi);
        else if (pick < 76 && str_len > 0)
            send_good_query();
        else if (pick < 82 && str_len > 0)
        begin
            // just past the end, or reversed bounds once the store is full
            if (str_len < STR_MAX)
            begin
                hi = IDX_W'(str_len);
                lo = IDX_W'($urandom_range(0, str_len));
            end
            else
            begin
                hi = IDX_W'($urandom_range(0, STR_MAX - 2));
                lo = hi + 1'b1;
            end
            send_word(REQ_QUERY, BYTE_W'($urandom), lo, hi);
        end
        else if (pick < 88)
            send_word(REQ_QUERY, BYTE_W'($urandom), lo, hi);
        else if (pick < 94)
            send_word(REQ_CLEAR, BYTE_W'($urandom), lo, hi);
        else
            send_word(REQ_UNUSED, BYTE_W'($urandom), lo, hi);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned target;
        target = items_sent + count;
        while (items_sent < target)
            random_word();
    endtask

    // bases change only with the block drained; appends leave no result, so let them finish
    task automatic write_bases(input logic [DATA_W-1:0] b1, input logic [DATA_W-1:0] b2);
        in_valid <= 1'b0;
        while (hash_expect_q.size() != 0)
            @(negedge clk);
        repeat (CFG_SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE_FIRST;
        cfg_data  <= b1;
        @(negedge clk);
        cfg_index <= CFG_BASE_SECOND;
        cfg_data  <= b2;
        @(negedge clk);
        cfg_we <= 1'b0;
        lane_base[0] = b1;
        lane_base[1] = b2;
        n_cfg++;
    endtask

    initial
    begin : result_sink
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                n_holds++;
            end
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        hash_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (hash_expect_q.size() == 0)
            begin
                $error("result word with no query pending: hash_first=%0d hash_second=%0d bad_range=%0b",
                       hash_first, hash_second, bad_range);
                err_count++;
            end
            else
            begin
                want = hash_expect_q.pop_front();
                n_checked++;
                if (hash_first !== want.h1)
                begin
                    $error("hash_first: expected %0d, got %0d", want.h1, hash_first);
                    err_count++;
                end
                if (hash_second !== want.h2)
                begin
                    $error("hash_second: expected %0d, got %0d", want.h2, hash_second);
                    err_count++;
                end
                if (bad_range !== want.bad)
                begin
                    $error("bad_range: expected %0b, got %0b", want.bad, bad_range);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, hash_expect_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = REQ_APPEND;
        char_code   = '0;
        left_index  = '0;
        right_index = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_BASE_FIRST;
        cfg_data    = '0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        lane_base[0] = BASE_FIRST_RST;
        lane_base[1] = BASE_SECOND_RST;
        for (int k = 0; k < 2; k++)
        begin
            for (int i = 0; i <= STR_MAX; i++)
            begin
                prefix_tab[k][i] = '0;
                power_tab[k][i]  = '0;
            end
            power_tab[k][0] = 1;
        end
        str_len = 0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
            send_word(dir_tab[i].req, dir_tab[i].ch, dir_tab[i].lo, dir_tab[i].hi,
                      dir_tab[i].typed, dir_tab[i].res);
        send_word(REQ_QUERY, 8'h00, 12'd0, 12'd0, 1'b1, '{30'd128, 30'd128, 1'b0});

        write_bases(DATA_W'($urandom), DATA_W'($urandom));
        run_random(400);
        write_bases('0, '0);
        run_random(60);
        write_bases(30'd1, 30'd1);
        run_random(60);
        // no clear here: the string keeps its old prefixes and powers
        write_bases({DATA_W{1'b1}}, {DATA_W{1'b1}});
        run_random(100);
        write_bases(MOD_FIRST - 1'b1, MOD_SECOND - 1'b1);
        run_random(100);
        write_bases(MOD_FIRST, MOD_SECOND);
        run_random(50);

        // receiver holds off while queries keep coming, so the block backs up
        write_bases(DATA_W'($urandom), DATA_W'($urandom));
        repeat (6) send_word(REQ_APPEND, BYTE_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
        hold_req = 1'b1;
        repeat (40) send_good_query();
        run_random(100);

        // fill the store to the top, push a few more bytes past it, query the far end
        write_bases(DATA_W'($urandom), DATA_W'($urandom));
        send_word(REQ_CLEAR, 8'h00, 12'd0, 12'd0);
        while (str_len < STR_MAX)
            send_word(REQ_APPEND, BYTE_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
        repeat (3) send_word(REQ_APPEND, BYTE_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
        send_word(REQ_QUERY, 8'h00, 12'd0,    12'd4095);
        send_word(REQ_QUERY, 8'h00, 12'd4095, 12'd4095);
        send_word(REQ_QUERY, 8'h00, 12'd0,    12'd0);
        send_word(REQ_QUERY, 8'h00, 12'd1,    12'd4095);
        send_word(REQ_QUERY, 8'h00, 12'd4095, 12'd4094, 1'b1, '{30'd0, 30'd0, 1'b1});
        repeat (30) send_good_query();

        // closing stretch at the reset bases with no idling on either side
        write_bases(BASE_FIRST_RST, BASE_SECOND_RST);
        idle_on = 1'b0;
        run_random(300);

        in_valid <= 1'b0;
        while (hash_expect_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("covered %0d appends (%0d dropped when full), %0d clears, %0d queries (%0d out of range)",
                 n_append, n_drop, n_clear, n_query, n_bad);
        $display("checked %0d result words over %0d base settings, %0d long output hold-offs",
                 n_checked, n_cfg, n_holds);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/dmsh_pkg.sv
hw/rtl/dmsh_modmul.sv
hw/rtl/double_mod_substring_hash_top.sv
dv/tb.sv
